>>> rtl/core/mkcc_pkg.sv
`timescale 1ns / 1ps

package mkcc_pkg;

   // Request kinds.
   localparam logic [1:0] REQ_KEY   = 2'd0;
   localparam logic [1:0] REQ_TICK  = 2'd1;
   localparam logic [1:0] REQ_DONE  = 2'd2;
   localparam logic [1:0] REQ_ABORT = 2'd3;

   // Key commands.
   localparam logic [2:0] CMD_PLAY      = 3'd0;
   localparam logic [2:0] CMD_STOP      = 3'd1;
   localparam logic [2:0] CMD_PAUSE     = 3'd2;
   localparam logic [2:0] CMD_PLAYPAUSE = 3'd3;
   localparam logic [2:0] CMD_NEXT      = 3'd4;
   localparam logic [2:0] CMD_PREV      = 3'd5;

   // Player states.
   localparam logic [1:0] PS_STOPPED = 2'd0;
   localparam logic [1:0] PS_PLAYING = 2'd1;
   localparam logic [1:0] PS_PAUSED  = 2'd2;

   // Result kinds.
   localparam logic [1:0] EV_SKIP_NEXT = 2'd0;
   localparam logic [1:0] EV_SKIP_PREV = 2'd1;
   localparam logic [1:0] EV_SKIP_END  = 2'd2;
   localparam logic [1:0] EV_DELIVER   = 2'd3;

   // Register indexes on the configuration port.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_IVL = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SKIP_IVL    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAUSE_IVL   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLAY_IVL    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLAY_THR  = 3'd4;

   localparam int unsigned IVL_W  = 24;
   localparam int unsigned POS_W  = 31;
   localparam int unsigned CSR_W  = 31;

   localparam logic [IVL_W-1:0] DEFAULT_IVL_RST = 24'd500000;
   localparam logic [IVL_W-1:0] SKIP_IVL_RST    = 24'd200000;
   localparam logic [IVL_W-1:0] PAUSE_IVL_RST   = 24'd100000;
   localparam logic [IVL_W-1:0] PLAY_IVL_RST    = 24'd10;
   localparam logic [POS_W-1:0] REPLAY_THR_RST  = 31'd3000;

   localparam logic signed [7:0] OFFSET_MAX = 8'sh7f;
   localparam logic signed [7:0] OFFSET_MIN = 8'sh80;

   // Output queue depth in result beats.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [1:0]       req_type;
      logic [2:0]       key_cmd;
      logic [1:0]       player_state;
      logic [POS_W-1:0] play_position;
   } req_item_type;

   typedef struct packed {
      logic [1:0]        event_kind;
      logic [1:0]        target_state;
      logic signed [7:0] track_offset;
      logic [POS_W-1:0]  target_position;
      logic              last_of_run;
   } rsp_item_type;

   typedef struct packed {
      logic [IVL_W-1:0] default_interval;
      logic [IVL_W-1:0] skip_interval;
      logic [IVL_W-1:0] pause_interval;
      logic [IVL_W-1:0] play_interval;
      logic [POS_W-1:0] replay_threshold;
   } cfg_type;

   // Up to two result beats produced by one item, first beat first.
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } res_pair_type;

endpackage

>>> rtl/core/mkcc_if.sv
`timescale 1ns / 1ps

interface mkcc_req_if;
   import mkcc_pkg::*;

   logic             valid;
   logic             ready;
   logic [1:0]       req_type;
   logic [2:0]       key_cmd;
   logic [1:0]       player_state;
   logic [POS_W-1:0] play_position;

   modport source (output valid, output req_type, output key_cmd, output player_state,
                   output play_position, input ready);
   modport sink   (input valid, input req_type, input key_cmd, input player_state,
                   input play_position, output ready);
endinterface

interface mkcc_rsp_if;
   import mkcc_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        event_kind;
   logic [1:0]        target_state;
   logic signed [7:0] track_offset;
   logic [POS_W-1:0]  target_position;
   logic              last_of_run;

   modport source (output valid, output event_kind, output target_state,
                   output track_offset, output target_position, output last_of_run,
                   input ready);
   modport sink   (input valid, input event_kind, input target_state,
                   input track_offset, input target_position, input last_of_run,
                   output ready);
endinterface

>>> rtl/core/media_key_command_coalescer_top.sv
`timescale 1ns / 1ps

// Media key command coalescer. Key beats (play, stop, pause, play/pause, next,
// previous) are merged into one pending event that carries a target player state,
// a saturating signed track offset and a position to restore. A play key while
// playing or a pause key while paused cancels the event; any other key, with the
// client idle, restarts a countdown whose length the opening key of the event
// selects from the interval registers; tick beats count it down, and on expiry with
// the client idle the block emits an optional skip-end notice followed by the event.
// A next key, and a previous key that skips back rather than rewinding the track,
// emits a notice beat at once. A completion beat frees the client and re-arms the
// countdown for a still pending event; an abort beat clears all engine state. The
// block accepts one request beat per clock while the queue has room. A beat is
// captured in an input register; its results go into a four-entry output queue that
// drives the response channel. The input register advances only while the queue has
// room for two beats, so a stalled response side stops request acceptance once the
// queue holds three or more results and a beat is waiting in the input register.
// Configuration writes take effect at the clock edge on which csr_we is high.

module media_key_command_coalescer_top (
   input  logic                           clock,
   input  logic                           reset,
   mkcc_req_if.sink                       req_ch,
   mkcc_rsp_if.source                     rsp_ch,
   input  logic                           csr_we,
   input  logic [mkcc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mkcc_pkg::CSR_W-1:0]     csr_wdata
);
   import mkcc_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   logic          in_valid_ff, in_valid_in;
   req_item_type  in_item_ff;
   req_item_type  req_item;
   logic          room_for_two;
   logic          advance;
   logic          req_fire;
   res_pair_type  res;
   rsp_item_type  head;
   logic          head_valid;

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DEFAULT_IVL: cfg_in.default_interval = csr_wdata[IVL_W-1:0];
            CSR_SKIP_IVL:    cfg_in.skip_interval    = csr_wdata[IVL_W-1:0];
            CSR_PAUSE_IVL:   cfg_in.pause_interval   = csr_wdata[IVL_W-1:0];
            CSR_PLAY_IVL:    cfg_in.play_interval    = csr_wdata[IVL_W-1:0];
            CSR_REPLAY_THR:  cfg_in.replay_threshold = csr_wdata[POS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.default_interval <= DEFAULT_IVL_RST;
         cfg_ff.skip_interval    <= SKIP_IVL_RST;
         cfg_ff.pause_interval   <= PAUSE_IVL_RST;
         cfg_ff.play_interval    <= PLAY_IVL_RST;
         cfg_ff.replay_threshold <= REPLAY_THR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register: the held beat moves into the engine whenever the output
   // queue can absorb the two results it might produce.
   assign advance      = in_valid_ff && room_for_two;
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign req_item.req_type      = req_ch.req_type;
   assign req_item.key_cmd       = req_ch.key_cmd;
   assign req_item.player_state  = req_ch.player_state;
   assign req_item.play_position = req_ch.play_position;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_item;
      end
   end

   mkcc_engine u_engine (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .item  (in_item_ff),
      .cfg   (cfg_ff),
      .res   (res)
   );

   mkcc_out_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (res),
      .room_for_two (room_for_two),
      .head_valid   (head_valid),
      .head         (head),
      .pop          (rsp_ch.ready)
   );

   assign rsp_ch.valid           = head_valid;
   assign rsp_ch.event_kind      = head.event_kind;
   assign rsp_ch.target_state    = head.target_state;
   assign rsp_ch.track_offset    = head.track_offset;
   assign rsp_ch.target_position = head.target_position;
   assign rsp_ch.last_of_run     = head.last_of_run;

   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !room_for_two) |=> in_valid_ff)
      else $error("held request beat dropped while the queue was full");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ch.ready)
      else $error("request side stalled with an empty input register");

   a_capture: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (in_valid_ff && in_item_ff == $past(req_item)))
      else $error("accepted request beat not captured");

endmodule

>>> rtl/core/mkcc_out_queue.sv
`timescale 1ns / 1ps

module mkcc_out_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  mkcc_pkg::res_pair_type push,
   output logic                  room_for_two,
   output logic                  head_valid,
   output mkcc_pkg::rsp_item_type head,
   input  logic                  pop
);
   import mkcc_pkg::*;

   rsp_item_type          mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic [QUEUE_AW-1:0]   wr_next;
   logic                  do_pop;

   assign head_valid   = (count_ff != '0);
   assign head         = mem_ff[rd_ptr_ff];
   assign room_for_two = (count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
   assign do_pop       = pop && head_valid;
   assign wr_next      = wr_ptr_ff + QUEUE_AW'(1);

   always_comb begin
      rd_ptr_in = rd_ptr_ff + QUEUE_AW'(do_pop);
      wr_ptr_in = wr_ptr_ff + QUEUE_AW'(push.count);
      count_in  = count_ff + (QUEUE_AW+1)'(push.count) - (QUEUE_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("output queue overfilled");

   a_pair_counted: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2 && !do_pop) |=> count_ff == $past(count_ff) + 2)
      else $error("two-beat push not counted");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd0 && do_pop) |=> count_ff == $past(count_ff) - 1)
      else $error("pop not counted");

endmodule

>>> rtl/core/mkcc_engine.sv
`timescale 1ns / 1ps

module mkcc_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  mkcc_pkg::req_item_type item,
   input  mkcc_pkg::cfg_type      cfg,
   output mkcc_pkg::res_pair_type res
);
   import mkcc_pkg::*;

   logic              pending_ff, pending_in;
   logic              busy_ff, busy_in;
   logic              nav_ff, nav_in;
   logic signed [7:0] offset_ff, offset_in;
   logic [1:0]        pstate_ff, pstate_in;
   logic [POS_W-1:0]  ppos_ff, ppos_in;
   logic [IVL_W-1:0]  interval_ff, interval_in;
   logic              running_ff, running_in;
   logic [IVL_W-1:0]  left_ff, left_in;

   always_comb begin
      logic              neutral;
      logic              was_pending;
      logic              restart;
      logic [POS_W-1:0]  cmp_pos;
      pending_in  = pending_ff;
      busy_in     = busy_ff;
      nav_in      = nav_ff;
      offset_in   = offset_ff;
      pstate_in   = pstate_ff;
      ppos_in     = ppos_ff;
      interval_in = interval_ff;
      running_in  = running_ff;
      left_in     = left_ff;
      res         = '0;
      neutral     = (item.key_cmd > CMD_PREV)
                 || (item.key_cmd == CMD_PLAY  && item.player_state == PS_PLAYING)
                 || (item.key_cmd == CMD_PAUSE && item.player_state == PS_PAUSED);
      was_pending = pending_ff;
      restart     = 1'b0;
      cmp_pos     = '0;

      case (item.req_type)
         REQ_KEY: begin
            if (neutral) begin
               pending_in = 1'b0;
               running_in = 1'b0;
            end else begin
               interval_in = cfg.default_interval;
               running_in  = 1'b0;
               pending_in  = 1'b1;
               if (!pending_ff) begin
                  offset_in = '0;
                  pstate_in = item.player_state;
                  nav_in    = 1'b0;
               end
               // The compared position is the request's own until the first navigation key, then the stored one.
               cmp_pos = (pending_ff && nav_ff) ? ppos_ff : item.play_position;
               case (item.key_cmd)
                  CMD_NEXT: begin
                     if (offset_in != OFFSET_MAX) begin
                        offset_in = offset_in + 8'sd1;
                     end
                     nav_in          = 1'b1;
                     res.count       = 2'd1;
                     res.first.event_kind  = EV_SKIP_NEXT;
                     res.first.last_of_run = 1'b1;
                     if (!was_pending) begin
                        interval_in = cfg.skip_interval;
                     end
                  end
                  CMD_PREV: begin
                     if (!nav_in && (item.player_state == PS_PLAYING ||
                                     item.player_state == PS_PAUSED) &&
                         cmp_pos > cfg.replay_threshold) begin
                        restart = 1'b1;
                     end else begin
                        res.count             = 2'd1;
                        res.first.event_kind  = EV_SKIP_PREV;
                        res.first.last_of_run = 1'b1;
                        if (offset_in != OFFSET_MIN) begin
                           offset_in = offset_in - 8'sd1;
                        end
                     end
                     nav_in = 1'b1;
                  end
                  CMD_PLAY: begin
                     pstate_in = PS_PLAYING;
                     if (!was_pending) begin
                        interval_in = cfg.play_interval;
                     end
                  end
                  CMD_PAUSE: begin
                     if (pstate_in == PS_PLAYING) begin
                        pstate_in = PS_PAUSED;
                        if (!was_pending) begin
                           interval_in = cfg.pause_interval;
                        end
                     end
                  end
                  CMD_PLAYPAUSE: begin
                     if (pstate_in == PS_PLAYING) begin
                        pstate_in = PS_PAUSED;
                        if (!was_pending) begin
                           interval_in = cfg.pause_interval;
                        end
                     end else begin
                        pstate_in = PS_PLAYING;
                        if (!was_pending) begin
                           interval_in = cfg.play_interval;
                        end
                     end
                  end
                  default: begin
                     pstate_in = PS_STOPPED;
                  end
               endcase
               ppos_in = (offset_in != 8'sd0 || restart) ? '0 : item.play_position;
               if (!busy_ff) begin
                  running_in = 1'b1;
                  left_in    = interval_in;
               end
            end
         end
         REQ_TICK: begin
            if (running_ff) begin
               if (left_ff > IVL_W'(1)) begin
                  left_in = left_ff - IVL_W'(1);
               end else begin
                  running_in = 1'b0;
                  left_in    = '0;
                  if (!busy_ff && pending_ff) begin
                     pending_in = 1'b0;
                     busy_in    = 1'b1;
                     if (nav_ff) begin
                        res.count                    = 2'd2;
                        res.first.event_kind         = EV_SKIP_END;
                        res.second.event_kind        = EV_DELIVER;
                        res.second.target_state      = pstate_ff;
                        res.second.track_offset      = offset_ff;
                        res.second.target_position   = ppos_ff;
                        res.second.last_of_run       = 1'b1;
                     end else begin
                        res.count                    = 2'd1;
                        res.first.event_kind         = EV_DELIVER;
                        res.first.target_state       = pstate_ff;
                        res.first.track_offset       = offset_ff;
                        res.first.target_position    = ppos_ff;
                        res.first.last_of_run        = 1'b1;
                     end
                  end
               end
            end
         end
         REQ_DONE: begin
            busy_in = 1'b0;
            if (pending_ff && !running_ff) begin
               running_in = 1'b1;
               left_in    = interval_ff;
            end
         end
         default: begin
            pending_in  = 1'b0;
            busy_in     = 1'b0;
            nav_in      = 1'b0;
            offset_in   = '0;
            pstate_in   = '0;
            ppos_in     = '0;
            interval_in = '0;
            running_in  = 1'b0;
            left_in     = '0;
         end
      endcase

      if (!fire) begin
         res.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= 1'b0;
         busy_ff     <= 1'b0;
         nav_ff      <= 1'b0;
         offset_ff   <= '0;
         pstate_ff   <= '0;
         ppos_ff     <= '0;
         interval_ff <= '0;
         running_ff  <= 1'b0;
         left_ff     <= '0;
      end else if (fire) begin
         pending_ff  <= pending_in;
         busy_ff     <= busy_in;
         nav_ff      <= nav_in;
         offset_ff   <= offset_in;
         pstate_ff   <= pstate_in;
         ppos_ff     <= ppos_in;
         interval_ff <= interval_in;
         running_ff  <= running_in;
         left_ff     <= left_in;
      end
   end

   a_pair_starts_with_end: assert property (@(posedge clock) disable iff (reset)
      res.count == 2'd2 |-> (res.first.event_kind == EV_SKIP_END &&
                             res.second.event_kind == EV_DELIVER))
      else $error("two-beat run is not skip end then deliver");

   a_deliver_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (fire && item.req_type == REQ_TICK && res.count != 2'd0) |=>
         (busy_ff && !pending_ff && !running_ff))
      else $error("delivery did not mark the client busy");

   a_no_timer_while_busy: assert property (@(posedge clock) disable iff (reset)
      (fire && item.req_type == REQ_KEY && busy_ff) |=> !running_ff)
      else $error("countdown armed while the client is busy");

endmodule
